>>> design/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and codes for the LRU cache simulator
// Field widths, action and outcome codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sacl_pkg;

   localparam int ADDR_W = 32;
   localparam int TAG_W  = 32;
   localparam int CNT_W  = 32;

   // action codes
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_STORE  = 2'd1;
   localparam logic [1:0] ACT_MODIFY = 2'd2;
   localparam logic [1:0] ACT_RSVD   = 2'd3;

   // first access outcome codes
   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_SET_BITS = 2'd0;
   localparam logic [1:0] CSR_WAYS     = 2'd1;
   localparam logic [1:0] CSR_OFFSET   = 2'd2;

   typedef struct packed {
      logic [2:0] set_index_bits;
      logic [2:0] ways_in_use;
      logic [4:0] block_offset_bits;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      set_index_bits:    3'd0,
      ways_in_use:       3'd1,
      block_offset_bits: 5'd4
   };

endpackage

>>> design/set_assoc_cache_lru_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim: set-associative cache simulator with true LRU
// Flow: an accepted access item waits in the two-entry front queue, its set
// row is read into a register, and the execute state does the read-modify-write
// of the row in the tag/rank memory; the next item is not begun until then.
// Reset (synchronous): clears valid bits, counters, queue and registers to
// their defaults; tag and rank storage is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim
   import sacl_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [4:0]        csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [ADDR_W-1:0] req_address,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_first_outcome,
   output logic              rsp_second_hit,
   output logic [CNT_W-1:0]  rsp_hit_total,
   output logic [CNT_W-1:0]  rsp_miss_total,
   output logic [CNT_W-1:0]  rsp_eviction_total
);

   localparam int IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

   cfg_type          cfg_ff, cfg_in;
   logic             q_valid;
   logic             q_pop;
   logic [IDX_W-1:0] q_set;
   logic [TAG_W-1:0] q_tag;
   logic             q_modify;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SET_BITS: cfg_in.set_index_bits    = csr_write_data[2:0];
            CSR_WAYS:     cfg_in.ways_in_use       = csr_write_data[2:0];
            CSR_OFFSET:   cfg_in.block_offset_bits = csr_write_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sacl_front #(
      .MAX_SET_BITS (MAX_SET_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .set_index_bits    (cfg_ff.set_index_bits),
      .block_offset_bits (cfg_ff.block_offset_bits),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_address       (req_address),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_set             (q_set),
      .q_tag             (q_tag),
      .q_modify          (q_modify)
   );

   sacl_back #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .ways_in_use        (cfg_ff.ways_in_use),
      .q_valid            (q_valid),
      .q_pop              (q_pop),
      .q_set              (q_set),
      .q_tag              (q_tag),
      .q_modify           (q_modify),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_first_outcome  (rsp_first_outcome),
      .rsp_second_hit     (rsp_second_hit),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total)
   );

endmodule

>>> design/sacl_front.sv
// ----------------------------------------------------------------------------
// sacl_front: request intake and address split
// Accepts access items, drops the reserved action, splits the address into
// set index and tag, and holds the result in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sacl_front
   import sacl_pkg::*;
#(
   parameter int MAX_SET_BITS = 6
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [2:0]                                set_index_bits,
   input  logic [4:0]                                block_offset_bits,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [1:0]                                req_action,
   input  logic [ADDR_W-1:0]                         req_address,
   output logic                                      q_valid,
   input  logic                                      q_pop,
   output logic [(MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)-1:0] q_set,
   output logic [TAG_W-1:0]                          q_tag,
   output logic                                      q_modify
);

   localparam int IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

   logic [2:0]        eff_sb;
   logic [5:0]        split_sum;
   logic [ADDR_W-1:0] shifted;
   logic [IDX_W-1:0]  set_mask;
   logic [IDX_W-1:0]  set_calc;
   logic [TAG_W-1:0]  tag_calc;
   logic              push;

   logic [IDX_W-1:0]  set_ff [2];
   logic [TAG_W-1:0]  tag_ff [2];
   logic [1:0]        modify_ff;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      if (32'(set_index_bits) > MAX_SET_BITS) begin
         eff_sb = 3'(MAX_SET_BITS);
      end else begin
         eff_sb = set_index_bits;
      end
      split_sum = {1'b0, block_offset_bits} + {3'b000, eff_sb};
      shifted   = req_address >> block_offset_bits;
      set_mask  = ~({IDX_W{1'b1}} << eff_sb);
      set_calc  = shifted[IDX_W-1:0] & set_mask;
      // a split that covers the whole address leaves no tag bits
      if (split_sum[5]) begin
         tag_calc = '0;
      end else begin
         tag_calc = req_address >> split_sum[4:0];
      end
   end

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign push      = req_valid && req_ready && (req_action != ACT_RSVD);

   assign q_set    = set_ff[rd_ptr_ff];
   assign q_tag    = tag_ff[rd_ptr_ff];
   assign q_modify = modify_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         set_ff[wr_ptr_ff]    <= set_calc;
         tag_ff[wr_ptr_ff]    <= tag_calc;
         modify_ff[wr_ptr_ff] <= (req_action == ACT_MODIFY);
      end
   end

endmodule

>>> design/sacl_back.sv
// ----------------------------------------------------------------------------
// sacl_back: set lookup, LRU update and statistics
// Reads one set row, resolves hit, fill or eviction, writes the row back,
// updates the counters and holds the result item until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sacl_back
   import sacl_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 4
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [2:0]                                ways_in_use,
   input  logic                                      q_valid,
   output logic                                      q_pop,
   input  logic [(MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)-1:0] q_set,
   input  logic [TAG_W-1:0]                          q_tag,
   input  logic                                      q_modify,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [1:0]                                rsp_first_outcome,
   output logic                                      rsp_second_hit,
   output logic [CNT_W-1:0]                          rsp_hit_total,
   output logic [CNT_W-1:0]                          rsp_miss_total,
   output logic [CNT_W-1:0]                          rsp_eviction_total
);

   localparam int IDX_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int ROWS   = 1 << MAX_SET_BITS;
   localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WI_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WC_W   = $clog2(MAX_WAYS + 1);
   localparam int ENT_W  = TAG_W + RANK_W;
   localparam int ROW_W  = MAX_WAYS * ENT_W;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic [ROW_W-1:0]    mem [ROWS];
   logic [MAX_WAYS-1:0] valid_ff [ROWS];

   logic                state_ff, state_in;
   logic [IDX_W-1:0]    set_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic                modify_ff;
   logic [ROW_W-1:0]    rd_row_ff;
   logic [CNT_W-1:0]    hits_ff, hits_in;
   logic [CNT_W-1:0]    miss_ff, miss_in;
   logic [CNT_W-1:0]    evict_ff, evict_in;
   logic                rsp_valid_ff;
   logic [1:0]          outcome_ff, outcome_in;
   logic                second_ff;

   logic [WC_W-1:0]     eff_ways;
   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] valid_row;
   logic [TAG_W-1:0]    tag_rd [MAX_WAYS];
   logic [RANK_W-1:0]   rank_rd [MAX_WAYS];
   logic [MAX_WAYS-1:0] hit_vec, inv_vec, max_vec;
   logic                hit_any, fill_any;
   logic [WI_W-1:0]     hit_way, fill_way, vic_way;
   logic [RANK_W-1:0]   hit_rank;
   logic [TAG_W-1:0]    tag_new [MAX_WAYS];
   logic [RANK_W-1:0]   rank_new [MAX_WAYS];
   logic [MAX_WAYS-1:0] valid_new;
   logic [ROW_W-1:0]    row_new;
   logic                exec;

   assign exec  = (state_ff == ST_EXEC);
   assign q_pop = (state_ff == ST_IDLE) && q_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (ways_in_use == 3'd0) begin
         eff_ways = WC_W'(1);
      end else if (32'(ways_in_use) > MAX_WAYS) begin
         eff_ways = WC_W'(MAX_WAYS);
      end else begin
         eff_ways = WC_W'(ways_in_use);
      end
      valid_row = valid_ff[set_ff];
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w]  = (32'(w) < 32'(eff_ways));
         tag_rd[w]  = rd_row_ff[w*ENT_W +: TAG_W];
         rank_rd[w] = rd_row_ff[w*ENT_W + TAG_W +: RANK_W];
         hit_vec[w] = in_use[w] && valid_row[w] && (tag_rd[w] == tag_ff);
         inv_vec[w] = in_use[w] && !valid_row[w];
      end
      // a way in use is a victim candidate when no way in use has a greater rank
      for (int w = 0; w < MAX_WAYS; w++) begin
         max_vec[w] = in_use[w];
         for (int v = 0; v < MAX_WAYS; v++) begin
            if (in_use[v] && (rank_rd[v] > rank_rd[w])) begin
               max_vec[w] = 1'b0;
            end
         end
      end
      hit_any  = |hit_vec;
      fill_any = |inv_vec;
      hit_way  = '0;
      fill_way = '0;
      vic_way  = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) hit_way = WI_W'(w);
         if (inv_vec[w]) fill_way = WI_W'(w);
         if (max_vec[w]) vic_way = WI_W'(w);
      end
      hit_rank = rank_rd[hit_way];
   end

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         tag_new[w]   = tag_rd[w];
         rank_new[w]  = rank_rd[w];
         valid_new[w] = valid_row[w];
         priority if (hit_any) begin
            if (WI_W'(w) == hit_way) begin
               rank_new[w] = '0;
            end else if (in_use[w] && valid_row[w] && (rank_rd[w] < hit_rank)
                         && (rank_rd[w] < RANK_MAX)) begin
               rank_new[w] = rank_rd[w] + 1'b1;
            end
         end else if (fill_any) begin
            if (WI_W'(w) == fill_way) begin
               valid_new[w] = 1'b1;
               tag_new[w]   = tag_ff;
               rank_new[w]  = '0;
            end else if (in_use[w] && valid_row[w] && (rank_rd[w] < RANK_MAX)) begin
               rank_new[w] = rank_rd[w] + 1'b1;
            end
         end else begin
            if (WI_W'(w) == vic_way) begin
               tag_new[w]  = tag_ff;
               rank_new[w] = '0;
            end else if (in_use[w] && (rank_rd[w] < RANK_MAX)) begin
               rank_new[w] = rank_rd[w] + 1'b1;
            end
         end
         row_new[w*ENT_W +: ENT_W] = {rank_new[w], tag_new[w]};
      end
   end

   always_comb begin
      // the second access of a modify always hits the line just touched
      hits_in  = hits_ff + CNT_W'(hit_any) + CNT_W'(modify_ff);
      miss_in  = miss_ff + CNT_W'(!hit_any);
      evict_in = evict_ff + CNT_W'(!hit_any && !fill_any);
      priority if (hit_any) begin
         outcome_in = OUT_HIT;
      end else if (fill_any) begin
         outcome_in = OUT_FILL;
      end else begin
         outcome_in = OUT_EVICT;
      end
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (q_pop) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_row_ff <= mem[q_set];
         set_ff    <= q_set;
         tag_ff    <= q_tag;
         modify_ff <= q_modify;
      end
      if (exec) begin
         mem[set_ff] <= row_new;
         outcome_ff  <= outcome_in;
         second_ff   <= modify_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         evict_ff     <= '0;
         for (int r = 0; r < ROWS; r++) begin
            valid_ff[r] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (exec) begin
            valid_ff[set_ff] <= valid_new;
            hits_ff          <= hits_in;
            miss_ff          <= miss_in;
            evict_ff         <= evict_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_outcome  = outcome_ff;
   assign rsp_second_hit     = second_ff;
   assign rsp_hit_total      = hits_ff;
   assign rsp_miss_total     = miss_ff;
   assign rsp_eviction_total = evict_ff;

   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      exec |=> (state_ff == ST_IDLE))
      else $error("execute state held for more than one cycle");

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      exec |-> !rsp_valid_ff)
      else $error("result produced while output register still full");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(exec))
      else $error("result valid without an executed item");

   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      (exec && !hit_any) |=> (miss_ff == $past(miss_ff) + 1'b1))
      else $error("miss counter did not advance on a miss");

endmodule
